// ----- design/lkct_pkg.sv -----
// ---------------------------------------------------------------------------
// lkct_pkg
// Shared types and constants of the keyed LRU cache table: payload beats,
// status codes, the link passed along the cell chain and the cell command.
// ---------------------------------------------------------------------------
`default_nettype none

package lkct_pkg;

    // Default number of cells in the table.
    localparam int LKCT_CAPACITY = 16;

    // Cell indices travel at a fixed width that covers the largest table.
    localparam int LKCT_IDX_W = 8;

    // Reset value of the entry limit register.
    localparam logic [4:0] LKCT_MAX_RESET = 5'd16;

    // Register indices of the configuration port.
    localparam logic LKCT_REG_LIMIT = 1'b0;

    // Action codes of an input beat.
    localparam logic ACT_ACCESS = 1'b0;
    localparam logic ACT_TRIM   = 1'b1;

    // Status codes of a result beat.
    localparam logic [2:0] ST_HIT       = 3'd0;
    localparam logic [2:0] ST_INSERTED  = 3'd1;
    localparam logic [2:0] ST_LOAD_FAIL = 3'd2;
    localparam logic [2:0] ST_DROPPED   = 3'd3;
    localparam logic [2:0] ST_TRIM_DONE = 3'd4;

    // Input beat.
    typedef struct packed {
        logic        action;
        logic [63:0] lookup_key;
        logic        load_ok;
    } t_req;

    // Result beat.
    typedef struct packed {
        logic [2:0] status;
        logic [3:0] slot;
        logic [4:0] evicted_count;
    } t_rsp;

    // Running search results handed from one cell to the next.
    typedef struct packed {
        logic                  match_found;
        logic [LKCT_IDX_W-1:0] match_idx;
        logic                  free_found;
        logic [LKCT_IDX_W-1:0] free_idx;
        logic                  min_found;
        logic [63:0]           min_stamp;
        logic [LKCT_IDX_W-1:0] min_idx;
    } t_link;

    // Operation applied to one cell.
    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_TOUCH  = 2'd1,
        OP_INSERT = 2'd2,
        OP_EVICT  = 2'd3
    } t_cell_op;

    // Command broadcast to all cells; only the addressed cell acts.
    typedef struct packed {
        t_cell_op              op;
        logic [LKCT_IDX_W-1:0] idx;
        logic [63:0]           key;
        logic [63:0]           stamp;
    } t_cell_cmd;

endpackage

`default_nettype wire

// ----- design/lkct_cell.sv -----
// ---------------------------------------------------------------------------
// lkct_cell
// One table entry: valid bit, key and use stamp. It merges its own entry into
// the running search results from the previous cell and registers them for
// the next cell, and applies the broadcast command when addressed.
// ---------------------------------------------------------------------------
`default_nettype none

module lkct_cell #(
    parameter int INDEX = 0
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire [63:0]               i_key,
    input  lkct_pkg::t_link          i_link,
    input  lkct_pkg::t_cell_cmd      i_cmd,
    output lkct_pkg::t_link          o_link
);
    import lkct_pkg::*;

    logic        r_valid;
    logic [63:0] r_key;
    logic [63:0] r_stamp;
    t_link       r_link;
    t_link       n_link;

    logic w_sel;
    logic w_hit;
    logic w_older;

    assign w_sel   = (i_cmd.idx == LKCT_IDX_W'(INDEX));
    assign w_hit   = r_valid && (r_key == i_key);
    assign w_older = r_valid && (!i_link.min_found || (r_stamp < i_link.min_stamp));

    // Merge this entry into the search results; lower cells win ties.
    always_comb begin
        n_link = i_link;
        if (!i_link.match_found && w_hit) begin
            n_link.match_found = 1'b1;
            n_link.match_idx   = LKCT_IDX_W'(INDEX);
        end
        if (!i_link.free_found && !r_valid) begin
            n_link.free_found = 1'b1;
            n_link.free_idx   = LKCT_IDX_W'(INDEX);
        end
        if (w_older) begin
            n_link.min_found = 1'b1;
            n_link.min_stamp = r_stamp;
            n_link.min_idx   = LKCT_IDX_W'(INDEX);
        end
    end

    // Link register towards the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= '0;
        end else begin
            r_link <= n_link;
        end
    end

    // Valid bit follows insert and evict commands.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_sel) begin
            case (i_cmd.op)
                OP_INSERT: r_valid <= 1'b1;
                OP_EVICT:  r_valid <= 1'b0;
                default:   r_valid <= r_valid;
            endcase
        end
    end

    // Key and stamp storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_sel) begin
            case (i_cmd.op)
                OP_INSERT: begin
                    r_key   <= i_cmd.key;
                    r_stamp <= i_cmd.stamp;
                end
                OP_TOUCH: begin
                    r_stamp <= i_cmd.stamp;
                end
                default: begin
                    r_stamp <= r_stamp;
                end
            endcase
        end
    end

    assign o_link = r_link;

endmodule

`default_nettype wire

// ----- design/lru_keyed_cache_table.sv -----
// ---------------------------------------------------------------------------
// lru_keyed_cache_table
// Fully associative table of keys with least recently used replacement.
//
//   Channel   Ports                                   Beat taken when
//   --------  --------------------------------------  ---------------------------
//   request   start, busy, i_req                      start high and busy low
//   result    o_done, o_rsp                           o_done high (one cycle)
//   config    psel, penable, pwrite, paddr, pwdata,   psel, penable, pwrite and
//             prdata, pready                          pready high
//
// The search results ripple through a chain of CAPACITY registered cells while
// the sequencer scans; a decision step follows each pass, and each eviction
// adds another pass and decision. The result strobe follows in the cycle after
// the final decision, the cycle in which busy drops.
// Reset is synchronous and clears all valid bits at once; no clearing pass.
// The result side cannot stall; each result is shown for one cycle only.
// ---------------------------------------------------------------------------
`default_nettype none

module lru_keyed_cache_table #(
    parameter int CAPACITY = lkct_pkg::LKCT_CAPACITY
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // request channel
    input  wire                 start,
    output logic                busy,
    input  lkct_pkg::t_req      i_req,
    // result channel
    output logic                o_done,
    output lkct_pkg::t_rsp      o_rsp,
    // configuration port
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [2:0]          paddr,
    input  wire  [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import lkct_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int MW = (CW > 5) ? CW : 5;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_DECIDE = 3'b100
    } t_state;

    t_state      r_state, n_state;
    logic [SW-1:0] r_cnt, n_cnt;
    t_req        r_req, n_req;
    logic [CW-1:0] r_count, n_count;
    logic [4:0]  r_evicted, n_evicted;
    logic [63:0] r_counter, n_counter;
    logic [4:0]  r_max;
    logic        r_done, n_done;
    t_rsp        r_rsp, n_rsp;

    t_cell_cmd   w_cmd;
    t_link       w_link [CAPACITY+1];
    t_link       w_last;

    logic [MW-1:0] w_max_ext;
    logic [CW-1:0] w_limit;
    logic [CW-1:0] w_keep;
    logic [63:0]   w_next_stamp;
    logic          w_cfg_wr;

    // Configuration port: one register, always ready.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= LKCT_MAX_RESET;
        end else if (w_cfg_wr && (paddr[2] == LKCT_REG_LIMIT)) begin
            r_max <= pwdata[4:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == LKCT_REG_LIMIT) begin
            prdata = {27'd0, r_max};
        end
    end

    // Cell chain; the first cell sees an empty search result.
    assign w_link[0] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        lkct_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_key   (r_req.lookup_key),
            .i_link  (w_link[g]),
            .i_cmd   (w_cmd),
            .o_link  (w_link[g+1])
        );
    end

    assign w_last = w_link[CAPACITY];

    // Effective limit and the number of old entries that may stay.
    assign w_max_ext = MW'(r_max);
    assign w_limit   = (w_max_ext < MW'(CAPACITY)) ? CW'(w_max_ext) : CW'(CAPACITY);

    always_comb begin
        if (r_req.action == ACT_TRIM) begin
            w_keep = w_limit;
        end else if (w_limit == '0) begin
            w_keep = '0;
        end else begin
            w_keep = w_limit - CW'(1);
        end
    end

    assign w_next_stamp = r_counter + 64'd1;

    // Sequencer: scan the chain, then decide on one step of the item.
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_req     = r_req;
        n_count   = r_count;
        n_evicted = r_evicted;
        n_counter = r_counter;
        n_done    = 1'b0;
        n_rsp     = r_rsp;
        w_cmd     = '{op: OP_NONE, idx: '0, key: r_req.lookup_key, stamp: w_next_stamp};

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req     = i_req;
                    n_cnt     = '0;
                    n_evicted = '0;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cnt == SW'(CAPACITY - 1)) begin
                    n_state = S_DECIDE;
                end else begin
                    n_cnt = r_cnt + SW'(1);
                end
            end
            S_DECIDE: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                n_rsp   = '{status: ST_TRIM_DONE, slot: '0, evicted_count: r_evicted};
                if (r_req.action == ACT_ACCESS && w_last.match_found) begin
                    // Hit: refresh the stamp.
                    w_cmd.op    = OP_TOUCH;
                    w_cmd.idx   = w_last.match_idx;
                    n_counter   = w_next_stamp;
                    n_rsp.status = ST_HIT;
                    n_rsp.slot   = w_last.match_idx[3:0];
                end else if (r_req.action == ACT_ACCESS && !r_req.load_ok) begin
                    n_rsp.status = ST_LOAD_FAIL;
                end else if (r_count > w_keep) begin
                    // Evict the oldest entry and scan again.
                    w_cmd.op  = OP_EVICT;
                    w_cmd.idx = w_last.min_idx;
                    n_count   = r_count - CW'(1);
                    n_evicted = r_evicted + 5'd1;
                    n_cnt     = '0;
                    n_state   = S_SCAN;
                    n_done    = 1'b0;
                    n_rsp     = r_rsp;
                end else if (r_req.action == ACT_TRIM) begin
                    n_rsp.status = ST_TRIM_DONE;
                end else if (w_limit == '0) begin
                    n_counter    = w_next_stamp;
                    n_rsp.status = ST_DROPPED;
                end else begin
                    // Insert into the lowest free cell.
                    w_cmd.op     = OP_INSERT;
                    w_cmd.idx    = w_last.free_idx;
                    n_count      = r_count + CW'(1);
                    n_counter    = w_next_stamp;
                    n_rsp.status = ST_INSERTED;
                    n_rsp.slot   = w_last.free_idx[3:0];
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_count   <= '0;
            r_evicted <= '0;
            r_counter <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_count   <= n_count;
            r_evicted <= n_evicted;
            r_counter <= n_counter;
            r_done    <= n_done;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_rsp <= n_rsp;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

`default_nettype wire

// ----- tb/lkct_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lkct_checker
// Scoreboard for the keyed LRU cache table. It watches the request, result
// and configuration channels, keeps its own copy of the cells, the use
// counter and the limit register, and compares every result beat field by
// field with the oldest expected one. Register reads are checked as well.
// ---------------------------------------------------------------------------
module lkct_checker #(
    parameter int CAPACITY = lkct_pkg::LKCT_CAPACITY
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire                 i_busy,
    input  lkct_pkg::t_req      i_req,
    input  wire                 i_done,
    input  lkct_pkg::t_rsp      i_rsp,
    input  wire                 i_psel,
    input  wire                 i_penable,
    input  wire                 i_pwrite,
    input  wire  [2:0]          i_paddr,
    input  wire  [31:0]         i_pwdata,
    input  wire  [31:0]         i_prdata,
    input  wire                 i_pready,
    output int                  o_errors,
    output int                  o_pending,
    output int                  o_checked
);

    import lkct_pkg::*;

    localparam logic [2:0] LIMIT_ADDR = 3'(4 * LKCT_REG_LIMIT);
    localparam int         MAX_REPORTS = 10;

    // Shadow copy of the cells, the use counter and the limit register.
    logic        cell_valid [CAPACITY];
    logic [63:0] cell_key   [CAPACITY];
    logic [63:0] cell_stamp [CAPACITY];
    logic [63:0] use_count;
    logic [4:0]  limit_reg;

    t_rsp        expected_rsp_q [$];
    int          err_count;
    int          checked_count;

    // Count a failure; only the first MAX_REPORTS are printed.
    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("[%0t] %s", $time, msg);
    endtask

    // Drop the least recently stamped entries until at most keep remain.
    function automatic int evict_down_to(input int keep);
        int held;
        int evicted;
        int victim;
        held = 0;
        evicted = 0;
        for (int i = 0; i < CAPACITY; i++)
            if (cell_valid[i])
                held++;
        while (held > keep) begin
            victim = -1;
            // Ties go to the lowest cell because of the strict compare.
            for (int i = 0; i < CAPACITY; i++)
                if (cell_valid[i] && (victim < 0 || cell_stamp[i] < cell_stamp[victim]))
                    victim = i;
            cell_valid[victim] = 1'b0;
            held--;
            evicted++;
        end
        return evicted;
    endfunction

    // Apply one request beat to the shadow cells and return its result.
    function automatic t_rsp lookup_result(input t_req r);
        t_rsp rsp;
        int   lim;
        int   at;
        bit   hit;
        rsp = '0;
        lim = (int'(limit_reg) > CAPACITY) ? CAPACITY : int'(limit_reg);
        at  = 0;
        hit = 1'b0;
        if (r.action == ACT_TRIM) begin
            rsp.status        = ST_TRIM_DONE;
            rsp.evicted_count = 5'(evict_down_to(lim));
        end else begin
            // Scan downwards so that the lowest matching cell wins.
            for (int i = CAPACITY - 1; i >= 0; i--)
                if (cell_valid[i] && cell_key[i] == r.lookup_key) begin
                    hit = 1'b1;
                    at  = i;
                end
            if (hit) begin
                use_count      = use_count + 64'd1;
                cell_stamp[at] = use_count;
                rsp.status     = ST_HIT;
                rsp.slot       = 4'(at);
            end else if (!r.load_ok) begin
                rsp.status = ST_LOAD_FAIL;
            end else begin
                use_count = use_count + 64'd1;
                if (lim == 0) begin
                    // Everything goes, and the new entry is dropped at once.
                    rsp.evicted_count = 5'(evict_down_to(0));
                    rsp.status        = ST_DROPPED;
                end else begin
                    rsp.evicted_count = 5'(evict_down_to(lim - 1));
                    for (int i = CAPACITY - 1; i >= 0; i--)
                        if (!cell_valid[i])
                            at = i;
                    cell_valid[at] = 1'b1;
                    cell_key[at]   = r.lookup_key;
                    cell_stamp[at] = use_count;
                    rsp.status     = ST_INSERTED;
                    rsp.slot       = 4'(at);
                end
            end
        end
        return rsp;
    endfunction

    // Results are compared before a new beat is predicted in the same cycle,
    // so a result can never be matched against its own request.
    always @(posedge i_clk) begin : watch
        t_rsp want;
        if (!i_rst_n) begin
            for (int i = 0; i < CAPACITY; i++) begin
                cell_valid[i] = 1'b0;
                cell_key[i]   = '0;
                cell_stamp[i] = '0;
            end
            use_count = '0;
            limit_reg = LKCT_MAX_RESET;
            expected_rsp_q.delete();
            err_count     = 0;
            checked_count = 0;
        end else begin
            if (i_done) begin
                if (expected_rsp_q.size() == 0) begin
                    flag_error($sformatf("unexpected result: status %0d slot %0d evicted %0d",
                                         i_rsp.status, i_rsp.slot, i_rsp.evicted_count));
                end else begin
                    want = expected_rsp_q.pop_front();
                    checked_count++;
                    if (i_rsp.status != want.status || i_rsp.slot != want.slot ||
                        i_rsp.evicted_count != want.evicted_count)
                        flag_error($sformatf({"result mismatch: expected status %0d slot %0d",
                                              " evicted %0d, got status %0d slot %0d",
                                              " evicted %0d"},
                                             want.status, want.slot, want.evicted_count,
                                             i_rsp.status, i_rsp.slot,
                                             i_rsp.evicted_count));
                end
            end

            // Register access beats.
            if (i_psel && i_penable && i_pready && i_paddr == LIMIT_ADDR) begin
                if (i_pwrite)
                    limit_reg = i_pwdata[4:0];
                else if (i_prdata[4:0] != limit_reg)
                    flag_error($sformatf("limit read back: expected %0d, got %0d",
                                         limit_reg, i_prdata[4:0]));
            end

            if (i_start && !i_busy)
                expected_rsp_q.push_back(lookup_result(i_req));
        end
        o_errors  <= err_count;
        o_pending <= expected_rsp_q.size();
        o_checked <= checked_count;
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the keyed LRU cache table. A short directed run
// walks through hits, inserts, failed loads, drops at a zero limit and trims
// at several limits; then random phases, each at its own limit, send bursts
// of requests, mostly accesses on a small key pool, so that hits and LRU
// evictions are frequent. Checking is done by lkct_checker.
// ---------------------------------------------------------------------------
module tb_top;

    import lkct_pkg::*;

    localparam int         NUM_PHASES     = 10;
    localparam int         ITEMS_PER_PHASE = 168;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         DRAIN_CYCLES   = 300;
    localparam int         SETTLE_CYCLES  = 4;
    localparam logic [2:0] LIMIT_ADDR     = 3'(4 * LKCT_REG_LIMIT);

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    t_req        req     = '0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic        busy;
    logic        done;
    t_rsp        rsp;
    logic [31:0] prdata;
    logic        pready;

    int          errors;
    int          pending;
    int          checked;
    int          quiet_cycles = 0;
    int          items_sent   = 0;
    int          trims_sent   = 0;
    int          limits_used  = 0;

    logic [63:0] key_pool [20];
    int          pool_size = 1;
    int          phase_limit [NUM_PHASES] = '{16, 4, 1, 0, 31, 9, 17, 2, -1, 16};

    lru_keyed_cache_table i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (req),
        .o_done  (done),
        .o_rsp   (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    lkct_checker i_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_req     (req),
        .i_done    (done),
        .i_rsp     (rsp),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .i_prdata  (prdata),
        .i_pready  (pready),
        .o_errors  (errors),
        .o_pending (pending),
        .o_checked (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: ends the run once no beat of any kind has moved for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || done || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    function automatic logic [63:0] random_key();
        return {$urandom, $urandom};
    endfunction

    function automatic t_req make_access(input logic [63:0] key, input logic ok);
        t_req r;
        r.action     = ACT_ACCESS;
        r.lookup_key = key;
        r.load_ok    = ok;
        return r;
    endfunction

    // Trim beats carry random key and load bits, which the block ignores.
    function automatic t_req make_trim();
        t_req r;
        r.action     = ACT_TRIM;
        r.lookup_key = random_key();
        r.load_ok    = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // Mostly well-formed traffic on the pool, with some fresh keys and trims.
    function automatic t_req random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            return make_trim();
        else if (pick < 12)
            return make_access(random_key(), 1'($urandom_range(0, 1)));
        else
            return make_access(key_pool[$urandom_range(0, pool_size - 1)],
                               1'($urandom_range(0, 9) != 0));
    endfunction

    // Present one request beat and hold it until the block takes it.
    task automatic send_item(input t_req r);
        start <= 1'b1;
        req   <= r;
        do @(posedge i_clk); while (busy);
        items_sent++;
        if (r.action == ACT_TRIM)
            trims_sent++;
    endtask

    task automatic idle_gap(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Wait until every expected result has come back.
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Change the limit while idle, then read it back.
    task automatic set_limit(input int lim);
        settle();
        reg_access(1'b1, LIMIT_ADDR, {27'd0, 5'(lim)});
        reg_access(1'b0, LIMIT_ADDR, '0);
        limits_used++;
    endtask

    initial begin
        int left;
        int burst;
        int lim;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        reg_access(1'b0, LIMIT_ADDR, '0);

        // Directed: failed load, inserts and hits at the key extremes.
        send_item(make_access(64'd0, 1'b0));
        send_item(make_access(64'd0, 1'b1));
        send_item(make_access('1, 1'b1));
        send_item(make_access(64'd0, 1'b1));
        send_item(make_access('1, 1'b0));
        send_item(make_access(64'h5555_5555_5555_5555, 1'b1));
        send_item(make_trim());

        // Lowered limit: trim evicts the oldest, an insert evicts another.
        set_limit(2);
        send_item(make_trim());
        send_item(make_access(64'hAAAA_AAAA_AAAA_AAAA, 1'b1));
        send_item(make_access(64'h5555_5555_5555_5555, 1'b1));

        // Zero limit: insert drops everything, failed load, empty trim.
        set_limit(0);
        send_item(make_access(64'h0123_4567_89AB_CDEF, 1'b1));
        send_item(make_access(64'h0123_4567_89AB_CDEF, 1'b0));
        send_item(make_trim());

        // Limit above capacity.
        set_limit(31);
        for (int i = 0; i < 4; i++) begin
            key_pool[i] = random_key();
            send_item(make_access(key_pool[i], 1'b1));
        end
        send_item(make_access(key_pool[2], 1'b1));
        set_limit(17);
        send_item(make_trim());

        // Limit one: each insert replaces the whole table.
        set_limit(1);
        send_item(make_access(random_key(), 1'b1));
        send_item(make_trim());
        send_item(make_access(random_key(), 1'b1));

        // Random phases, each at its own limit and with its own key pool.
        for (int p = 0; p < NUM_PHASES; p++) begin
            lim = (phase_limit[p] < 0) ? $urandom_range(0, 31) : phase_limit[p];
            set_limit(lim);
            pool_size = ((lim > 16) ? 16 : lim) + 4;
            for (int i = 0; i < pool_size; i++)
                key_pool[i] = random_key();
            send_item(make_trim());
            left = ITEMS_PER_PHASE;
            while (left > 0) begin
                burst = $urandom_range(1, 16);
                while (burst > 0 && left > 0) begin
                    send_item(random_item());
                    burst--;
                    left--;
                end
                if ($urandom_range(0, 3) != 0)
                    idle_gap($urandom_range(1, 30));
            end
        end

        // Drain and give the verdict.
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d requests, %0d of them trims, over %0d limit settings",
                 items_sent, trims_sent, limits_used);
        $display("%0d results compared, %0d failures", checked, errors);
        if (errors == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
